### sv/rotation_matrix_to_quaternion_macros.svh
// assertion macros used by the rotation matrix to quaternion rtl
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

// same-cycle implication, checked after reset
`define RMQ_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rmq assertion failed");

// next-cycle implication, checked after reset
`define RMQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rmq assertion failed");

`endif

### sv/rmq_pkg.sv
// types and constants of the rotation matrix to quaternion block
`timescale 1ns / 1ps
package rmq_pkg;
   localparam int ELEM_WIDTH   = 16;
   localparam int TRANS_WIDTH  = 32;
   localparam int OUT_FRAC     = 14;
   localparam int QUAT_WIDTH   = OUT_FRAC + 2;
   localparam int QUAT_W_WIDTH = OUT_FRAC + 1;
   localparam int QUAT_LIMIT   = 1 << OUT_FRAC;
   localparam int ONE_VAL      = 1 << (ELEM_WIDTH - 2);
   localparam int CAND_WIDTH   = ELEM_WIDTH + 2;
   localparam int MAG_WIDTH    = ELEM_WIDTH + 1;
   localparam int SQ_WIDTH     = 2 * MAG_WIDTH;
   localparam int SUM_WIDTH    = SQ_WIDTH + 2;
   localparam int X_SHIFT      = 2 * OUT_FRAC + 2;
   localparam int RES_WIDTH    = SUM_WIDTH + 2 * OUT_FRAC + 6;
   localparam int ROOT_STEPS   = OUT_FRAC + 1;
   localparam int LANE_COUNT   = 4;
   localparam int FRONT_STAGES = 4;
   localparam int LATENCY      = FRONT_STAGES + ROOT_STEPS;

   typedef enum logic [1:0] {PICK_X, PICK_Y, PICK_Z, PICK_W} pick_type;

   typedef logic signed [ELEM_WIDTH-1:0]  elem_type;
   typedef logic signed [TRANS_WIDTH-1:0] trans_type;
   typedef logic signed [CAND_WIDTH-1:0]  cand_type;
   typedef logic [MAG_WIDTH-1:0]          mag_type;
   typedef logic [SQ_WIDTH-1:0]           sq_type;
   typedef logic [SUM_WIDTH-1:0]          sum_type;
   typedef logic signed [RES_WIDTH-1:0]   res_type;
   typedef logic [ROOT_STEPS-1:0]         root_type;
   typedef logic signed [QUAT_WIDTH-1:0]  quat_type;

   typedef struct packed {
      trans_type x;
      trans_type y;
      trans_type z;
   } trans_set_type;
endpackage

### sv/rmq_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
interface rmq_req_if;
   import rmq_pkg::*;
   logic      valid;
   logic      ready;
   elem_type  r11, r12, r13, r21, r22, r23, r31, r32, r33;
   trans_type trans_x_in, trans_y_in, trans_z_in;

   modport source (output valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
                   trans_x_in, trans_y_in, trans_z_in, input ready);
   modport sink (input valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
                 trans_x_in, trans_y_in, trans_z_in, output ready);
endinterface

interface rmq_rsp_if;
   import rmq_pkg::*;
   logic                    valid;
   logic                    ready;
   trans_type               trans_x_out, trans_y_out, trans_z_out;
   quat_type                quat_x, quat_y, quat_z;
   logic [QUAT_W_WIDTH-1:0] quat_w;

   modport source (output valid, trans_x_out, trans_y_out, trans_z_out,
                   quat_x, quat_y, quat_z, quat_w, input ready);
   modport sink (input valid, trans_x_out, trans_y_out, trans_z_out,
                 quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

### sv/rmq_root_lane.sv
// pipelined rounded scaling of one quaternion part by the inverse root of the norm
`timescale 1ns / 1ps
module rmq_root_lane (
   input  logic                      clock,
   input  logic                      en,
   input  logic [rmq_pkg::SUM_WIDTH-1:0]  s,
   input  logic signed [rmq_pkg::RES_WIDTH-1:0] r0,
   input  logic                      neg,
   output logic signed [rmq_pkg::QUAT_WIDTH-1:0] part
);
   import rmq_pkg::*;

   res_type  r_ff   [ROOT_STEPS];
   res_type  p_ff   [ROOT_STEPS];
   sum_type  s_ff   [ROOT_STEPS];
   root_type n_ff   [ROOT_STEPS];
   logic     neg_ff [ROOT_STEPS];

   // one result bit per stage, residual r = x^2 - d^2 s, p = d s
   for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
      localparam int B = OUT_FRAC - k;
      res_type  r_cur, p_cur, s_ext, t_val, cand, r_in, p_in;
      sum_type  s_cur;
      root_type n_cur, n_in;
      logic     neg_cur, take;

      if (k == 0) begin : g_first
         assign r_cur   = r0;
         assign p_cur   = -res_type'(s);
         assign s_cur   = s;
         assign n_cur   = '0;
         assign neg_cur = neg;
      end else begin : g_next
         assign r_cur   = r_ff[k-1];
         assign p_cur   = p_ff[k-1];
         assign s_cur   = s_ff[k-1];
         assign n_cur   = n_ff[k-1];
         assign neg_cur = neg_ff[k-1];
      end

      // trial of bit b: d grows by 2^(b+1)
      always_comb begin
         s_ext = res_type'(s_cur);
         t_val = (p_cur << (B + 2)) + (s_ext << (2 * B + 2));
         cand  = r_cur - t_val;
         take  = !cand[RES_WIDTH-1];
         r_in  = take ? cand : r_cur;
         p_in  = take ? p_cur + (s_ext << (B + 1)) : p_cur;
         n_in  = n_cur;
         n_in[B] = take;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k]   <= r_in;
            p_ff[k]   <= p_in;
            s_ff[k]   <= s_cur;
            n_ff[k]   <= n_in;
            neg_ff[k] <= neg_cur;
         end
      end
   end

   // apply sign
   assign part = neg_ff[ROOT_STEPS-1] ? -quat_type'(n_ff[ROOT_STEPS-1])
                                      : quat_type'(n_ff[ROOT_STEPS-1]);
endmodule

### sv/rotation_matrix_to_quaternion.sv
// rotation matrix to unit quaternion converter with translation pass-through
//
//   channel | direction | contents
//   req_ch  | in        | r11..r33 (q2.14), trans_x_in..trans_z_in
//   rsp_ch  | out       | trans_x_out..trans_z_out, quat_x..quat_z (q2.14), quat_w
//
// a request passes 20 register stages, the first loaded at the accepting edge
// (4 front stages: candidates, case select, squares, norm; 15 root stages, one
// result bit each; output). one request enters per cycle; the pipeline only stops
// when the skid stage holds a response. reset clears only the valid bits, those
// of the output and skid stages included.
`timescale 1ns / 1ps
`include "rotation_matrix_to_quaternion_macros.svh"
module rotation_matrix_to_quaternion (
   input  logic      clock,
   input  logic      reset,
   rmq_req_if.sink   req_ch,
   rmq_rsp_if.source rsp_ch
);
   import rmq_pkg::*;

   typedef struct packed {
      trans_set_type           trans;
      quat_type                qx;
      quat_type                qy;
      quat_type                qz;
      logic [QUAT_W_WIDTH-1:0] qw;
   } rsp_data_type;

   logic          en;
   logic          take;
   logic          vld_ff   [LATENCY];
   trans_set_type trans_ff [LATENCY];

   cand_type c_in [4];
   cand_type c_ff [4];
   cand_type pa_in, pb_in, pc_in, dx_in, dy_in, dz_in;
   cand_type pa_ff, pb_ff, pc_ff, dx_ff, dy_ff, dz_ff;
   cand_type e11, e12, e13, e21, e22, e23, e31, e32, e33, one_c;

   pick_type pick;
   cand_type q_sel [LANE_COUNT];
   logic     flip;
   mag_type  mag_in [LANE_COUNT];
   mag_type  mag_ff [LANE_COUNT];
   logic     neg2_in [LANE_COUNT];
   logic     neg2_ff [LANE_COUNT];

   sq_type   sq_ff   [LANE_COUNT];
   logic     neg3_ff [LANE_COUNT];

   sum_type  sum_in;
   sum_type  sum_ff;
   res_type  r0_in [LANE_COUNT];
   res_type  r0_ff [LANE_COUNT];
   logic     neg4_ff [LANE_COUNT];

   quat_type part [LANE_COUNT];

   rsp_data_type pipe_dat;
   rsp_data_type out_ff, out_in, skid_ff, skid_in;
   logic         out_vld_ff, out_vld_in, skid_vld_ff, skid_vld_in;
   logic         pipe_vld;

   assign en           = !skid_vld_ff;
   assign req_ch.ready = en && !reset;
   assign take         = out_vld_ff && rsp_ch.ready;
   assign pipe_vld     = vld_ff[LATENCY-1];

   // valid bits and translation shift line
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LATENCY; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_ch.valid;
         for (int k = 1; k < LATENCY; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         trans_ff[0] <= '{x: req_ch.trans_x_in, y: req_ch.trans_y_in,
                          z: req_ch.trans_z_in};
         for (int k = 1; k < LATENCY; k++) trans_ff[k] <= trans_ff[k-1];
      end
   end

   // stage 1: candidates and off-diagonal sums and differences
   always_comb begin
      e11   = cand_type'(req_ch.r11);
      e12   = cand_type'(req_ch.r12);
      e13   = cand_type'(req_ch.r13);
      e21   = cand_type'(req_ch.r21);
      e22   = cand_type'(req_ch.r22);
      e23   = cand_type'(req_ch.r23);
      e31   = cand_type'(req_ch.r31);
      e32   = cand_type'(req_ch.r32);
      e33   = cand_type'(req_ch.r33);
      one_c = cand_type'(ONE_VAL);
      c_in[0] = one_c + e11 - e22 - e33;
      c_in[1] = one_c - e11 + e22 - e33;
      c_in[2] = one_c - e11 - e22 + e33;
      c_in[3] = one_c + e11 + e22 + e33;
      pa_in   = e12 + e21;
      pb_in   = e13 + e31;
      pc_in   = e23 + e32;
      dx_in   = e23 - e32;
      dy_in   = e31 - e13;
      dz_in   = e12 - e21;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff  <= c_in;
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         pc_ff <= pc_in;
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         dz_ff <= dz_in;
      end
   end

   // stage 2: largest candidate, lowest index wins a tie; sign fold
   always_comb begin
      pick = PICK_X;
      if (c_ff[1] > c_ff[0]) pick = PICK_Y;
      case (pick)
         PICK_X:  if (c_ff[2] > c_ff[0]) pick = PICK_Z;
         default: if (c_ff[2] > c_ff[1]) pick = PICK_Z;
      endcase
      case (pick)
         PICK_X:  if (c_ff[3] > c_ff[0]) pick = PICK_W;
         PICK_Y:  if (c_ff[3] > c_ff[1]) pick = PICK_W;
         default: if (c_ff[3] > c_ff[2]) pick = PICK_W;
      endcase
      case (pick)
         PICK_X: begin
            q_sel[0] = c_ff[0]; q_sel[1] = pa_ff; q_sel[2] = pb_ff; q_sel[3] = dx_ff;
         end
         PICK_Y: begin
            q_sel[0] = pa_ff; q_sel[1] = c_ff[1]; q_sel[2] = pc_ff; q_sel[3] = dy_ff;
         end
         PICK_Z: begin
            q_sel[0] = pb_ff; q_sel[1] = pc_ff; q_sel[2] = c_ff[2]; q_sel[3] = dz_ff;
         end
         default: begin
            q_sel[0] = dx_ff; q_sel[1] = dy_ff; q_sel[2] = dz_ff; q_sel[3] = c_ff[3];
         end
      endcase
      flip = q_sel[3][CAND_WIDTH-1];
      for (int i = 0; i < LANE_COUNT; i++) begin
         neg2_in[i] = q_sel[i][CAND_WIDTH-1] ^ flip;
         mag_in[i]  = q_sel[i][CAND_WIDTH-1] ? mag_type'(-q_sel[i])
                                             : mag_type'(q_sel[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff  <= mag_in;
         neg2_ff <= neg2_in;
      end
   end

   // stage 3: squares
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < LANE_COUNT; i++) begin
            sq_ff[i]   <= sq_type'(mag_ff[i]) * sq_type'(mag_ff[i]);
            neg3_ff[i] <= neg2_ff[i];
         end
      end
   end

   // stage 4: squared norm and starting residuals
   always_comb begin
      sum_in = (sum_type'(sq_ff[0]) + sum_type'(sq_ff[1]))
             + (sum_type'(sq_ff[2]) + sum_type'(sq_ff[3]));
      for (int i = 0; i < LANE_COUNT; i++)
         r0_in[i] = (res_type'(sq_ff[i]) << X_SHIFT) - res_type'(sum_in);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff  <= sum_in;
         r0_ff   <= r0_in;
         neg4_ff <= neg3_ff;
      end
   end

   // root stages, one lane per part
   for (genvar i = 0; i < LANE_COUNT; i++) begin : g_lane
      rmq_root_lane u_lane (
         .clock (clock),
         .en    (en),
         .s     (sum_ff),
         .r0    (r0_ff[i]),
         .neg   (neg4_ff[i]),
         .part  (part[i])
      );
   end

   // output register and skid stage
   always_comb begin
      pipe_dat.trans = trans_ff[LATENCY-1];
      pipe_dat.qx    = part[0];
      pipe_dat.qy    = part[1];
      pipe_dat.qz    = part[2];
      pipe_dat.qw    = part[3][QUAT_W_WIDTH-1:0];

      out_in      = out_ff;
      out_vld_in  = out_vld_ff;
      skid_in     = skid_ff;
      skid_vld_in = skid_vld_ff;
      if (skid_vld_ff) begin
         if (take) begin
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (pipe_vld) begin
         if (!out_vld_ff || take) begin
            out_in     = pipe_dat;
            out_vld_in = 1'b1;
         end else begin
            skid_in     = pipe_dat;
            skid_vld_in = 1'b1;
         end
      end else if (take) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_ch.valid       = out_vld_ff;
   assign rsp_ch.trans_x_out = out_ff.trans.x;
   assign rsp_ch.trans_y_out = out_ff.trans.y;
   assign rsp_ch.trans_z_out = out_ff.trans.z;
   assign rsp_ch.quat_x      = out_ff.qx;
   assign rsp_ch.quat_y      = out_ff.qy;
   assign rsp_ch.quat_z      = out_ff.qz;
   assign rsp_ch.quat_w      = out_ff.qw;

   // checks
   `RMQ_ASSERT_IMPLY(a_skid_needs_out, clock, reset, skid_vld_ff, out_vld_ff)
   `RMQ_ASSERT_NEXT(a_skid_catches, clock, reset, pipe_vld && !skid_vld_ff && out_vld_ff && !rsp_ch.ready, skid_vld_ff)
   `RMQ_ASSERT_IMPLY(a_quat_w_range, clock, reset, out_vld_ff, out_ff.qw <= QUAT_W_WIDTH'(QUAT_LIMIT))
   `RMQ_ASSERT_IMPLY(a_quat_x_range, clock, reset, out_vld_ff, (out_ff.qx <= quat_type'(QUAT_LIMIT)) && (out_ff.qx >= -quat_type'(QUAT_LIMIT)))
endmodule

### tb/rmq_tb_if.sv
// testbench types for pose requests and expected quaternion responses
`timescale 1ns / 1ps
package rmq_tb_pkg;
   import rmq_pkg::*;

   // one pose request as driven into the block
   typedef struct {
      elem_type  m[9];
      trans_type tx, ty, tz;
   } pose_req_type;

   // one expected quaternion response
   typedef struct {
      trans_type             tx, ty, tz;
      quat_type              qx, qy, qz;
      logic [QUAT_W_WIDTH-1:0] qw;
   } quat_rsp_type;
endpackage

### tb/rotation_matrix_to_quaternion_test.sv
// testbench of the rotation matrix to quaternion block
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_test;
   import rmq_pkg::*;
   import rmq_tb_pkg::*;

   // quaternion predictor and pending response store
   class quat_scoreboard;
      quat_rsp_type pending_quats[$];
      int           errors = 0;

      // rounded |q| * 2^14 / sqrt(s): largest n with (2n-1)^2 s <= q^2 2^30
      function automatic logic [15:0] scale_part(longint unsigned aq,
                                                logic [127:0] s);
         logic [127:0]    rhs;
         logic [15:0]     n;
         logic [15:0]     t;
         logic [127:0]    d;
         rhs = (128'(aq) * 128'(aq)) << (2 * OUT_FRAC + 2);
         n = 0;
         for (int b = OUT_FRAC; b >= 0; b--) begin
            t = n | (16'd1 << b);
            d = 128'(2 * t - 1);
            if (s * d * d <= rhs) n = t;
         end
         return n;
      endfunction

      // note an accepted pose and queue its quaternion
      function void note_pose(pose_req_type p);
         longint       m[9];
         longint       c[4], q[4];
         longint       one;
         int           pick;
         logic [127:0] s;
         logic [15:0]  n[4];
         longint       v[4];
         quat_rsp_type r;
         one = longint'(ONE_VAL);
         foreach (m[i]) m[i] = longint'(p.m[i]);
         c[0] = one + m[0] - m[4] - m[8];
         c[1] = one - m[0] + m[4] - m[8];
         c[2] = one - m[0] - m[4] + m[8];
         c[3] = one + m[0] + m[4] + m[8];
         pick = 0;
         for (int i = 1; i < 4; i++) if (c[i] > c[pick]) pick = i;
         case (pick_type'(pick))
            PICK_X: begin
               q[0] = c[0]; q[1] = m[1] + m[3]; q[2] = m[2] + m[6]; q[3] = m[5] - m[7];
            end
            PICK_Y: begin
               q[0] = m[3] + m[1]; q[1] = c[1]; q[2] = m[5] + m[7]; q[3] = m[6] - m[2];
            end
            PICK_Z: begin
               q[0] = m[6] + m[2]; q[1] = m[7] + m[5]; q[2] = c[2]; q[3] = m[1] - m[3];
            end
            default: begin
               q[0] = m[5] - m[7]; q[1] = m[6] - m[2]; q[2] = m[1] - m[3]; q[3] = c[3];
            end
         endcase
         // flip sign so w is non-negative
         if (q[3] < 0) foreach (q[i]) q[i] = -q[i];
         s = 0;
         foreach (q[i]) s += 128'(q[i] < 0 ? -q[i] : q[i]) * 128'(q[i] < 0 ? -q[i] : q[i]);
         foreach (q[i]) begin
            n[i] = scale_part(q[i] < 0 ? -q[i] : q[i], s);
            v[i] = q[i] < 0 ? -longint'(n[i]) : longint'(n[i]);
         end
         r.tx = p.tx; r.ty = p.ty; r.tz = p.tz;
         r.qx = quat_type'(v[0]); r.qy = quat_type'(v[1]); r.qz = quat_type'(v[2]);
         r.qw = v[3][QUAT_W_WIDTH-1:0];
         pending_quats = {pending_quats, r};
      endfunction

      // compare one response with the oldest expectation
      function void check_quat(quat_rsp_type a);
         quat_rsp_type e;
         if (pending_quats.size() == 0) begin
            $display("%0t: unexpected response tx=%h qx=%0d", $time, a.tx, a.qx);
            errors++;
            return;
         end
         e = pending_quats.pop_front();
         if (a.tx !== e.tx) begin
            $display("%0t: trans_x expected %h actual %h", $time, e.tx, a.tx); errors++;
         end
         if (a.ty !== e.ty) begin
            $display("%0t: trans_y expected %h actual %h", $time, e.ty, a.ty); errors++;
         end
         if (a.tz !== e.tz) begin
            $display("%0t: trans_z expected %h actual %h", $time, e.tz, a.tz); errors++;
         end
         if (a.qx !== e.qx) begin
            $display("%0t: quat_x expected %0d actual %0d", $time, e.qx, a.qx); errors++;
         end
         if (a.qy !== e.qy) begin
            $display("%0t: quat_y expected %0d actual %0d", $time, e.qy, a.qy); errors++;
         end
         if (a.qz !== e.qz) begin
            $display("%0t: quat_z expected %0d actual %0d", $time, e.qz, a.qz); errors++;
         end
         if (a.qw !== e.qw) begin
            $display("%0t: quat_w expected %0d actual %0d", $time, e.qw, a.qw); errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   rmq_req_if req_ch ();
   rmq_rsp_if rsp_ch ();
   quat_scoreboard board = new();
   bit  stim_done = 0;

   rotation_matrix_to_quaternion u_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   initial begin
      req_ch.valid = 0;
      rsp_ch.ready = 0;
      req_ch.r11 = 0; req_ch.r12 = 0; req_ch.r13 = 0;
      req_ch.r21 = 0; req_ch.r22 = 0; req_ch.r23 = 0;
      req_ch.r31 = 0; req_ch.r32 = 0; req_ch.r33 = 0;
      req_ch.trans_x_in = 0; req_ch.trans_y_in = 0; req_ch.trans_z_in = 0;
   end

   // drive one request, hold until accepted
   task automatic send_pose(pose_req_type p);
      req_ch.valid <= 1;
      req_ch.r11 <= p.m[0]; req_ch.r12 <= p.m[1]; req_ch.r13 <= p.m[2];
      req_ch.r21 <= p.m[3]; req_ch.r22 <= p.m[4]; req_ch.r23 <= p.m[5];
      req_ch.r31 <= p.m[6]; req_ch.r32 <= p.m[7]; req_ch.r33 <= p.m[8];
      req_ch.trans_x_in <= p.tx; req_ch.trans_y_in <= p.ty; req_ch.trans_z_in <= p.tz;
      do @(posedge clock); while (!req_ch.ready);
      board.note_pose(p);
   endtask

   task automatic idle_gap(int n);
      if (n > 0) begin
         req_ch.valid <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   // random element: full range, near-rotation values or extremes
   function automatic elem_type pick_elem();
      case ($urandom_range(0, 5))
         0:       return elem_type'($urandom);
         1:       return $urandom_range(0, 1) ? elem_type'(16'h8000) : elem_type'(16'h7fff);
         2:       return elem_type'(ONE_VAL) * ($urandom_range(0, 1) ? 1 : -1);
         3:       return 0;
         default: return elem_type'(int'($urandom_range(0, 2 * ONE_VAL)) - ONE_VAL);
      endcase
   endfunction

   function automatic pose_req_type random_pose();
      pose_req_type p;
      int           axis;
      foreach (p.m[i]) p.m[i] = pick_elem();
      // bias toward one dominant diagonal so every case is chosen
      if ($urandom_range(0, 1)) begin
         axis = $urandom_range(0, 3);
         for (int i = 0; i < 3; i++)
            p.m[4 * i] = (axis == 3 || axis == i) ? elem_type'(ONE_VAL - $urandom_range(0, 3000))
                                                  : elem_type'(-ONE_VAL + $urandom_range(0, 3000));
      end
      p.tx = trans_type'($urandom); p.ty = trans_type'($urandom); p.tz = trans_type'($urandom);
      return p;
   endfunction

   function automatic pose_req_type diag_pose(elem_type a, elem_type b, elem_type c);
      pose_req_type p;
      foreach (p.m[i]) p.m[i] = 0;
      p.m[0] = a; p.m[4] = b; p.m[8] = c;
      p.tx = 32'h7fffffff; p.ty = 32'h80000000; p.tz = 32'hffffffff;
      return p;
   endfunction

   // stimulus
   initial begin
      pose_req_type p;
      int           left;
      repeat (2) @(posedge clock);
      reset <= 0;
      // identity, half turns, ties between candidates, w sign flip, extremes
      send_pose(diag_pose(ONE_VAL, ONE_VAL, ONE_VAL));
      send_pose(diag_pose(ONE_VAL, -ONE_VAL, -ONE_VAL));
      send_pose(diag_pose(-ONE_VAL, ONE_VAL, -ONE_VAL));
      send_pose(diag_pose(-ONE_VAL, -ONE_VAL, ONE_VAL));
      send_pose(diag_pose(0, 0, 0));
      send_pose(diag_pose(0, 0, -ONE_VAL));
      send_pose(diag_pose(16'h8000, 16'h8000, 16'h8000));
      send_pose(diag_pose(16'h7fff, 16'h7fff, 16'h7fff));
      send_pose(diag_pose(16'h7fff, 16'h8000, 16'h8000));
      p = diag_pose(0, 0, 0);
      foreach (p.m[i]) p.m[i] = 16'h8000;
      send_pose(p);
      foreach (p.m[i]) p.m[i] = 16'h7fff;
      send_pose(p);
      foreach (p.m[i]) p.m[i] = 16'hffff;
      p.tx = 0; p.ty = 0; p.tz = 0;
      send_pose(p);
      // negative w in the x case, and zero w
      p = diag_pose(ONE_VAL, -ONE_VAL, -ONE_VAL);
      p.m[5] = -1000; p.m[7] = 1000;
      send_pose(p);
      p.m[5] = 500; p.m[7] = 500;
      send_pose(p);
      p = diag_pose(ONE_VAL / 2, ONE_VAL / 2, ONE_VAL / 2);
      p.m[1] = 300; p.m[3] = -300; p.m[2] = -16000; p.m[6] = 16000;
      send_pose(p);
      // random bursts
      left = 1850;
      while (left > 0) begin
         int burst;
         burst = $urandom_range(1, 40);
         for (int i = 0; i < burst && left > 0; i++) begin
            send_pose(random_pose());
            left--;
         end
         idle_gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 12));
      end
      req_ch.valid <= 0;
      stim_done = 1;
   end

   // receiver stall pattern and response check
   initial begin
      int phase;
      phase = 0;
      forever begin
         @(posedge clock);
         phase++;
         if ((phase / 400) % 2 == 0) rsp_ch.ready <= 1;
         else rsp_ch.ready <= ($urandom_range(0, 3) != 0) && (phase % 7 != 3);
      end
   end

   always @(posedge clock) begin
      quat_rsp_type a;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         a.tx = rsp_ch.trans_x_out; a.ty = rsp_ch.trans_y_out; a.tz = rsp_ch.trans_z_out;
         a.qx = rsp_ch.quat_x; a.qy = rsp_ch.quat_y; a.qz = rsp_ch.quat_z;
         a.qw = rsp_ch.quat_w;
         board.check_quat(a);
      end
   end

   // end of run
   initial begin
      wait (stim_done);
      while (board.pending_quats.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      if (board.errors == 0 && board.pending_quats.size() == 0)
         $display("rotation_matrix_to_quaternion: match");
      else
         $display("rotation_matrix_to_quaternion: mismatch");
      $finish;
   end

   initial begin
      #2000000;
      $display("rotation_matrix_to_quaternion: mismatch");
      $finish;
   end
endmodule

### filelist.f
+incdir+sv
sv/rmq_pkg.sv
sv/rmq_if.sv
sv/rmq_root_lane.sv
sv/rotation_matrix_to_quaternion.sv
tb/rmq_tb_if.sv
tb/rotation_matrix_to_quaternion_test.sv
